// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bus address decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bus decoder assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bus decoder assertion failed");

`endif

// ----- rtl/cbad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus address decoder package
// Shared types, codes and constants of the bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

   localparam int ROM_OFFSET_BITS = 22;
   localparam int SRAM_ADDR_BITS  = 13;

   localparam int ADDR_WIDTH   = 24;
   localparam int DATA_WIDTH   = 8;
   localparam int OFFSET_WIDTH = 22;
   localparam int MASK_WIDTH   = 13;
   localparam int CYCLE_WIDTH  = 4;

   localparam logic [ADDR_WIDTH-1:0] ROM_MASK =
      ADDR_WIDTH'((32'd1 << ROM_OFFSET_BITS) - 32'd1);
   localparam logic [MASK_WIDTH-1:0] HIROM_SRAM_MASK =
      MASK_WIDTH'(32'h1FFF & ((32'd1 << SRAM_ADDR_BITS) - 32'd1));

   localparam logic [CYCLE_WIDTH-1:0] CYCLES_FAST = 4'd6;
   localparam logic [CYCLE_WIDTH-1:0] CYCLES_SLOW = 4'd8;

   localparam logic [DATA_WIDTH-1:0] OPEN_BUS_FF = 8'hFF;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_MAP_LOROM = 1'b0,
      CSR_SRAM_MASK = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      TGT_ROM   = 3'd0,
      TGT_WRAM  = 3'd1,
      TGT_SRAM  = 3'd2,
      TGT_PPU   = 3'd3,
      TGT_IO    = 3'd4,
      TGT_JOY   = 3'd5,
      TGT_CONST = 3'd6,
      TGT_DROP  = 3'd7
   } target_type;

   // How the back end forms the offset from the address.
   typedef enum logic [2:0] {
      OFS_ZERO       = 3'd0,
      OFS_WRAM_LO    = 3'd1,
      OFS_WRAM_BANK  = 3'd2,
      OFS_LOROM      = 3'd3,
      OFS_HIROM      = 3'd4,
      OFS_SRAM_FIXED = 3'd5,
      OFS_SRAM_MASK  = 3'd6,
      OFS_LOW16      = 3'd7
   } offset_sel_type;

   typedef struct packed {
      logic                  map_lorom;
      logic [MASK_WIDTH-1:0] sram_mask;
   } cfg_type;

   typedef struct packed {
      target_type            tgt;
      offset_sel_type        sel;
      logic                  const_ff;
      logic                  fast;
      logic                  is_write;
      logic [DATA_WIDTH-1:0] store_data;
      logic [ADDR_WIDTH-1:0] address;
   } cmd_type;

endpackage

// ----- rtl/cbad_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus decoder front end
// Accepts bus accesses and classifies them by target and offset form.
// ----------------------------------------------------------------------------
module cbad_front import cbad_pkg::*; (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [ADDR_WIDTH-1:0] req_bus_address,
   input  logic [DATA_WIDTH-1:0] req_write_data,
   input  cfg_type               cfg,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               cmd
);

   logic       wr;
   logic [7:0] bank;
   logic [2:0] sub;
   logic       sys;
   logic       mid_page;
   target_type drop_tgt;

   assign wr       = req_type;
   assign bank     = req_bus_address[23:16];
   assign sub      = req_bus_address[15:13];
   assign sys      = ~bank[6];
   assign mid_page = sys && (sub != 3'd0) && (sub <= 3'd3);
   assign drop_tgt = wr ? TGT_DROP : TGT_CONST;

   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      cmd.tgt        = drop_tgt;
      cmd.sel        = OFS_ZERO;
      cmd.const_ff   = 1'b0;
      cmd.fast       = mid_page;
      cmd.is_write   = wr;
      cmd.store_data = wr ? req_write_data : '0;
      cmd.address    = req_bus_address;

      priority if (sys && sub == 3'd0) begin
         cmd.tgt = TGT_WRAM;
         cmd.sel = OFS_WRAM_LO;
      end else if (bank == 8'h7E || bank == 8'h7F) begin
         cmd.tgt = TGT_WRAM;
         cmd.sel = OFS_WRAM_BANK;
      end else if (cfg.map_lorom && !wr && bank[6:0] < 7'h60 && sub[2]) begin
         cmd.tgt = TGT_ROM;
         cmd.sel = OFS_LOROM;
      end else if (!cfg.map_lorom && (bank == 8'h70 || bank == 8'h71)) begin
         cmd.tgt = TGT_SRAM;
         cmd.sel = OFS_SRAM_FIXED;
      end else if (!cfg.map_lorom && !wr && !mid_page) begin
         cmd.tgt = TGT_ROM;
         cmd.sel = OFS_HIROM;
      end else if (sys) begin
         unique case (req_bus_address[15:12])
            4'h2: begin
               cmd.tgt = TGT_PPU;
               cmd.sel = OFS_LOW16;
            end
            4'h4: begin
               if (req_bus_address[11:9] == 3'b001) begin
                  cmd.tgt = TGT_IO;
                  cmd.sel = OFS_LOW16;
               end else if (req_bus_address[11:1] == 11'h00B) begin
                  cmd.tgt = TGT_JOY;
                  cmd.sel = OFS_LOW16;
               end
            end
            4'h6, 4'h7: begin
               if (!cfg.map_lorom) begin
                  cmd.tgt = TGT_SRAM;
                  cmd.sel = OFS_SRAM_MASK;
               end else begin
                  cmd.const_ff = ~wr;
               end
            end
            default: cmd.const_ff = ~wr;
         endcase
      end else if (bank >= 8'hD0 && bank <= 8'hFE) begin
         cmd.const_ff = 1'b0;
      end else if (bank == 8'h70) begin
         if (wr || cfg.sram_mask != '0) begin
            cmd.tgt = TGT_SRAM;
            cmd.sel = OFS_SRAM_MASK;
         end else begin
            cmd.tgt = TGT_CONST;
         end
      end else if (bank == 8'h60) begin
         cmd.const_ff = 1'b0;
      end else begin
         cmd.const_ff = ~wr;
      end
   end

endmodule

// ----- rtl/cbad_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus decoder command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module cbad_queue import cbad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/cbad_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus decoder back end
// Forms the target offset and result fields and holds them for transfer.
// ----------------------------------------------------------------------------
module cbad_back import cbad_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    queue_empty,
   input  cmd_type                 head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_target,
   output logic [OFFSET_WIDTH-1:0] rsp_target_offset,
   output logic [DATA_WIDTH-1:0]   rsp_constant_value,
   output logic [CYCLE_WIDTH-1:0]  rsp_access_cycles,
   output logic                    rsp_is_write,
   output logic [DATA_WIDTH-1:0]   rsp_store_data
);

   logic                    valid_ff, valid_in;
   logic [2:0]              target_ff;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [DATA_WIDTH-1:0]   const_ff;
   logic [CYCLE_WIDTH-1:0]  cycles_ff;
   logic                    write_ff;
   logic [DATA_WIDTH-1:0]   data_ff;
   logic                    load;

   // Load a new result when the slot is empty or its transfer completes.
   assign load     = ~queue_empty & (~valid_ff | rsp_ready);
   assign pop      = load;
   assign valid_in = load | (valid_ff & ~rsp_ready);

   always_comb begin
      logic [ADDR_WIDTH-1:0] rom_lo;
      logic [ADDR_WIDTH-1:0] rom_hi;
      rom_lo = {2'b00, head.address[22:16], head.address[14:0]} & ROM_MASK;
      rom_hi = head.address & ROM_MASK;
      unique case (head.sel)
         OFS_ZERO:       offset_in = '0;
         OFS_WRAM_LO:    offset_in = {9'd0, head.address[12:0]};
         OFS_WRAM_BANK:  offset_in = {5'd0, head.address[16], head.address[15:0]};
         OFS_LOROM:      offset_in = rom_lo[OFFSET_WIDTH-1:0];
         OFS_HIROM:      offset_in = rom_hi[OFFSET_WIDTH-1:0];
         OFS_SRAM_FIXED: offset_in = {9'd0, head.address[12:0] & HIROM_SRAM_MASK};
         OFS_SRAM_MASK:  offset_in = {9'd0, head.address[12:0] & cfg.sram_mask};
         OFS_LOW16:      offset_in = {6'd0, head.address[15:0]};
         default:        offset_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         target_ff <= head.tgt;
         offset_ff <= offset_in;
         const_ff  <= head.const_ff ? OPEN_BUS_FF : '0;
         cycles_ff <= head.fast ? CYCLES_FAST : CYCLES_SLOW;
         write_ff  <= head.is_write;
         data_ff   <= head.store_data;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_target         = target_ff;
   assign rsp_target_offset  = offset_ff;
   assign rsp_constant_value = const_ff;
   assign rsp_access_cycles  = cycles_ff;
   assign rsp_is_write       = write_ff;
   assign rsp_store_data     = data_ff;

endmodule

// ----- rtl/console_bus_address_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console bus address decoder
// Resolves 24-bit CPU bus accesses to a target store and offset under
// LoROM or HiROM cartridge mapping.
// ----------------------------------------------------------------------------
// One access is taken per clock cycle while req_ready is high: the front
// end classifies the access in the accept cycle and writes it into a
// two-entry command queue, and the back end turns the queue head into the
// registered result. The result register and the queue let a stalled
// result side hold up to two more accesses before req_ready drops.
// Configuration writes must only be issued while no access is in flight.
// Reads of ROM resolve to a 22-bit offset, work RAM to a 17-bit offset,
// battery SRAM to an address masked by sram_mask (the full 13-bit mask in
// HiROM banks 70-71), register targets to the low 16 address bits; writes
// to ROM or unmapped space come back as dropped writes, and reads of
// unmapped space as a constant byte of 0x00 or 0xFF.
// ----------------------------------------------------------------------------
module console_bus_address_decoder import cbad_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [ADDR_WIDTH-1:0]   req_bus_address,
   input  logic [DATA_WIDTH-1:0]   req_write_data,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_target,
   output logic [OFFSET_WIDTH-1:0] rsp_target_offset,
   output logic [DATA_WIDTH-1:0]   rsp_constant_value,
   output logic [CYCLE_WIDTH-1:0]  rsp_access_cycles,
   output logic                    rsp_is_write,
   output logic [DATA_WIDTH-1:0]   rsp_store_data,
   // configuration write port
   input  logic                    csr_we,
   input  logic [0:0]              csr_index,
   input  logic [MASK_WIDTH-1:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head;

   // Update the addressed mapping register; hold the other.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_LOROM: cfg_in.map_lorom = csr_wdata[0];
            CSR_SRAM_MASK: cfg_in.sram_mask = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_lorom <= 1'b1;
         cfg_ff.sram_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify each transferred access and push it into the queue.
   cbad_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_bus_address (req_bus_address),
      .req_write_data  (req_write_data),
      .cfg             (cfg_ff),
      .queue_full      (queue_full),
      .push            (push),
      .cmd             (push_cmd)
   );

   // Hold classified accesses while the result side stalls.
   cbad_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   // Form offsets and present the registered result.
   cbad_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .queue_empty        (queue_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target         (rsp_target),
      .rsp_target_offset  (rsp_target_offset),
      .rsp_constant_value (rsp_constant_value),
      .rsp_access_cycles  (rsp_access_cycles),
      .rsp_is_write       (rsp_is_write),
      .rsp_store_data     (rsp_store_data)
   );

endmodule

// ----- rtl/cbad_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus decoder port checker
// Port-level assertions on the result channel of the bus address decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbad_checker import cbad_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [2:0]              rsp_target,
   input logic [OFFSET_WIDTH-1:0] rsp_target_offset,
   input logic [DATA_WIDTH-1:0]   rsp_constant_value,
   input logic [CYCLE_WIDTH-1:0]  rsp_access_cycles,
   input logic                    rsp_is_write,
   input logic [DATA_WIDTH-1:0]   rsp_store_data
);

   // Drop any pending result on reset.
   `ASSERT_CLK(a_reset_clears_valid, clock, reset |=> !rsp_valid)

   // Hold a stalled result until its transfer.
   `ASSERT_CLK_RST(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) && $stable(rsp_target_offset))

   `ASSERT_CLK_RST(a_cycles_legal, clock, reset, rsp_valid |-> rsp_access_cycles == CYCLES_FAST || rsp_access_cycles == CYCLES_SLOW)

   // Reads never drop and never carry store data; writes never read a constant.
   `ASSERT_CLK_RST(a_kind_consistent, clock, reset, rsp_valid |-> (rsp_is_write ? (rsp_target != TGT_CONST && rsp_constant_value == '0) : (rsp_target != TGT_DROP && rsp_store_data == '0)))

   `ASSERT_CLK_RST(a_unmapped_zero_offset, clock, reset, rsp_valid && (rsp_target == TGT_CONST || rsp_target == TGT_DROP) |-> rsp_target_offset == '0)

endmodule

bind console_bus_address_decoder cbad_checker u_cbad_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_target         (rsp_target),
   .rsp_target_offset  (rsp_target_offset),
   .rsp_constant_value (rsp_constant_value),
   .rsp_access_cycles  (rsp_access_cycles),
   .rsp_is_write       (rsp_is_write),
   .rsp_store_data     (rsp_store_data)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus address decoder testbench
// Sends 24-bit read and write accesses through the request channel under
// LoROM and HiROM mapping with several SRAM sizes, and checks every result
// transfer against a hand-written result or the bench's own access decoder.
// A short directed table comes first, then 1560 random accesses in eight
// register settings, with random sender gaps and result-side stalls in most phases.
// ----------------------------------------------------------------------------
module testbench;
   import cbad_pkg::*;

   // Expected fields of one result transfer, in port order.
   typedef struct packed {
      target_type              tgt;
      logic [OFFSET_WIDTH-1:0] offset;
      logic [DATA_WIDTH-1:0]   const_val;
      logic [CYCLE_WIDTH-1:0]  cycles;
      logic                    is_write;
      logic [DATA_WIDTH-1:0]   store_data;
   } access_result_type;

   // One row of the directed table: the register setting it needs, the
   // access itself, and a hand-written result where one is obvious.
   typedef struct packed {
      logic                    lorom;
      logic [MASK_WIDTH-1:0]   mask;
      logic                    wr;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [DATA_WIDTH-1:0]   wdata;
      logic                    typed;
      access_result_type       want;
   } directed_row_type;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 195;
   localparam int DRAIN_CYCLES  = 4;

   localparam access_result_type NOT_TYPED = '0;

   // Rows without a typed result are checked against the decoder below.
   localparam directed_row_type DIRECTED [25] = '{
      // LoROM, no SRAM (reset setting)
      '{1'b1, 13'h0000, 1'b0, 24'h000000, 8'h00, 1'b1,
        '{TGT_WRAM, 22'h000000, 8'h00, CYCLES_SLOW, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b1, 24'h7FFFFF, 8'hFF, 1'b1,
        '{TGT_WRAM, 22'h01FFFF, 8'h00, CYCLES_SLOW, 1'b1, 8'hFF}},
      '{1'b1, 13'h0000, 1'b0, 24'h008000, 8'h00, 1'b1,
        '{TGT_ROM, 22'h000000, 8'h00, CYCLES_SLOW, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b0, 24'hDFFFFF, 8'h00, 1'b0, NOT_TYPED},
      '{1'b1, 13'h0000, 1'b1, 24'h808000, 8'hA5, 1'b1,
        '{TGT_DROP, 22'h000000, 8'h00, CYCLES_SLOW, 1'b1, 8'hA5}},
      '{1'b1, 13'h0000, 1'b0, 24'h002100, 8'h00, 1'b1,
        '{TGT_PPU, 22'h002100, 8'h00, CYCLES_FAST, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b1, 24'h8043FF, 8'h3C, 1'b0, NOT_TYPED},
      '{1'b1, 13'h0000, 1'b0, 24'h004016, 8'h00, 1'b1,
        '{TGT_JOY, 22'h004016, 8'h00, CYCLES_FAST, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b1, 24'h004017, 8'h01, 1'b0, NOT_TYPED},
      '{1'b1, 13'h0000, 1'b0, 24'h004000, 8'h00, 1'b1,
        '{TGT_CONST, 22'h000000, 8'h00, CYCLES_FAST, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b1, 24'h003000, 8'h55, 1'b1,
        '{TGT_DROP, 22'h000000, 8'h00, CYCLES_FAST, 1'b1, 8'h55}},
      '{1'b1, 13'h0000, 1'b0, 24'h005000, 8'h00, 1'b1,
        '{TGT_CONST, 22'h000000, 8'hFF, CYCLES_FAST, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b0, 24'h006000, 8'h00, 1'b0, NOT_TYPED},
      // bank 70 with no SRAM size: reads give zero, writes still hit SRAM
      '{1'b1, 13'h0000, 1'b0, 24'h700000, 8'h00, 1'b1,
        '{TGT_CONST, 22'h000000, 8'h00, CYCLES_SLOW, 1'b0, 8'h00}},
      '{1'b1, 13'h0000, 1'b1, 24'h701234, 8'h80, 1'b1,
        '{TGT_SRAM, 22'h000000, 8'h00, CYCLES_SLOW, 1'b1, 8'h80}},
      '{1'b1, 13'h0000, 1'b0, 24'h600000, 8'h00, 1'b0, NOT_TYPED},
      '{1'b1, 13'h0000, 1'b0, 24'hD00000, 8'h00, 1'b0, NOT_TYPED},
      '{1'b1, 13'h0000, 1'b0, 24'hFFFFFF, 8'h00, 1'b1,
        '{TGT_CONST, 22'h000000, 8'hFF, CYCLES_SLOW, 1'b0, 8'h00}},
      // HiROM, full SRAM
      '{1'b0, 13'h1FFF, 1'b0, 24'h701FFF, 8'h00, 1'b1,
        '{TGT_SRAM, 22'h001FFF, 8'h00, CYCLES_SLOW, 1'b0, 8'h00}},
      '{1'b0, 13'h1FFF, 1'b1, 24'h71FFFF, 8'h5A, 1'b0, NOT_TYPED},
      '{1'b0, 13'h1FFF, 1'b0, 24'hFFFFFF, 8'h00, 1'b1,
        '{TGT_ROM, 22'h3FFFFF, 8'h00, CYCLES_SLOW, 1'b0, 8'h00}},
      '{1'b0, 13'h1FFF, 1'b0, 24'h007ABC, 8'h00, 1'b0, NOT_TYPED},
      '{1'b0, 13'h1FFF, 1'b1, 24'h408000, 8'h00, 1'b0, NOT_TYPED},
      // HiROM, no SRAM size: the 6000-7FFF window still targets SRAM
      '{1'b0, 13'h0000, 1'b1, 24'h006000, 8'h7E, 1'b1,
        '{TGT_SRAM, 22'h000000, 8'h00, CYCLES_FAST, 1'b1, 8'h7E}},
      '{1'b0, 13'h0000, 1'b0, 24'hFE0000, 8'h00, 1'b0, NOT_TYPED}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = 1'b0;
   logic [ADDR_WIDTH-1:0]   req_bus_address = '0;
   logic [DATA_WIDTH-1:0]   req_write_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [2:0]              rsp_target;
   logic [OFFSET_WIDTH-1:0] rsp_target_offset;
   logic [DATA_WIDTH-1:0]   rsp_constant_value;
   logic [CYCLE_WIDTH-1:0]  rsp_access_cycles;
   logic                    rsp_is_write;
   logic [DATA_WIDTH-1:0]   rsp_store_data;
   logic                    csr_we = 1'b0;
   logic [0:0]              csr_index = CSR_MAP_LOROM;
   logic [MASK_WIDTH-1:0]   csr_wdata = '0;

   // Decoder registers as the bench believes them to be.
   logic                    cur_lorom = 1'b1;
   logic [MASK_WIDTH-1:0]   cur_mask = '0;

   access_result_type       pending_results [$];
   int                      mismatch_count = 0;
   int                      cycle_count = 0;

   // Sender burst state and result-side stall state.
   int                      burst_left = 0;
   int                      gap_limit = 3;
   int                      stall_mode = 1;
   logic [15:0]             stall_pattern = '0;
   logic [5:0]              stall_age = '0;

   console_bus_address_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target         (rsp_target),
      .rsp_target_offset  (rsp_target_offset),
      .rsp_constant_value (rsp_constant_value),
      .rsp_access_cycles  (rsp_access_cycles),
      .rsp_is_write       (rsp_is_write),
      .rsp_store_data     (rsp_store_data),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // Resolve one access to its target, offset and cost.
   function automatic access_result_type predict_access(
      input logic                  lorom,
      input logic [MASK_WIDTH-1:0] mask,
      input logic                  wr,
      input logic [ADDR_WIDTH-1:0] addr,
      input logic [DATA_WIDTH-1:0] wdata
   );
      access_result_type r;
      logic [7:0]        bank;
      logic [2:0]        sub;
      logic [15:0]       lo;
      logic [6:0]        mb;
      logic              sys;
      logic              fast_window;
      target_type        miss;
      logic [7:0]        miss_val;

      bank        = addr[23:16];
      sub         = addr[15:13];
      lo          = addr[15:0];
      mb          = bank[6:0];
      sys         = !bank[6];
      fast_window = sys && sub >= 3'd1 && sub <= 3'd3;
      miss        = wr ? TGT_DROP : TGT_CONST;
      miss_val    = wr ? 8'h00 : OPEN_BUS_FF;

      r            = '0;
      r.cycles     = fast_window ? CYCLES_FAST : CYCLES_SLOW;
      r.is_write   = wr;
      r.store_data = wr ? wdata : 8'h00;

      // Work RAM pages come first in both mappings.
      if (sys && sub == 3'd0) begin
         r.tgt    = TGT_WRAM;
         r.offset = OFFSET_WIDTH'(lo[12:0]);
         return r;
      end
      if (bank[7:1] == 7'h3F) begin
         r.tgt    = TGT_WRAM;
         r.offset = OFFSET_WIDTH'({bank[0], lo});
         return r;
      end
      if (lorom) begin
         if (!wr && mb < 7'h60 && sub >= 3'd4) begin
            r.tgt    = TGT_ROM;
            r.offset = OFFSET_WIDTH'(ADDR_WIDTH'({mb, lo[14:0]}) & ROM_MASK);
            return r;
         end
      end else begin
         if (bank[7:1] == 7'h38) begin
            r.tgt    = TGT_SRAM;
            r.offset = OFFSET_WIDTH'(addr[12:0] & HIROM_SRAM_MASK);
            return r;
         end
         if (!wr && !fast_window) begin
            r.tgt    = TGT_ROM;
            r.offset = OFFSET_WIDTH'(addr & ROM_MASK);
            return r;
         end
      end

      // Whatever is left: registers, SRAM windows and unmapped space.
      r.tgt = miss;
      if (mb < 7'h40) begin
         case (lo[15:12])
            4'h2: begin
               r.tgt    = TGT_PPU;
               r.offset = OFFSET_WIDTH'(lo);
            end
            4'h4: begin
               if (lo[11:9] == 3'b001) begin
                  r.tgt    = TGT_IO;
                  r.offset = OFFSET_WIDTH'(lo);
               end else if (lo[15:1] == 15'h200B) begin
                  r.tgt    = TGT_JOY;
                  r.offset = OFFSET_WIDTH'(lo);
               end
            end
            4'h6, 4'h7: begin
               if (!lorom) begin
                  r.tgt    = TGT_SRAM;
                  r.offset = OFFSET_WIDTH'(lo & {3'b000, mask});
               end else begin
                  r.const_val = miss_val;
               end
            end
            default: r.const_val = miss_val;
         endcase
      end else if (bank >= 8'hD0 && bank <= 8'hFE) begin
         r.const_val = 8'h00;
      end else if (bank == 8'h70) begin
         if (wr || mask != '0) begin
            r.tgt    = TGT_SRAM;
            r.offset = OFFSET_WIDTH'(lo & {3'b000, mask});
         end else begin
            r.tgt = TGT_CONST;
         end
      end else if (bank != 8'h60) begin
         r.const_val = miss_val;
      end
      return r;
   endfunction

   // Present one access and hold it until the request transfer. The sender
   // runs in bursts; a new burst may open with a random gap.
   task automatic send_access(
      input logic                  wr,
      input logic [ADDR_WIDTH-1:0] addr,
      input logic [DATA_WIDTH-1:0] wdata,
      input logic                  typed,
      input access_result_type     want
   );
      int gap;

      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_limit > 0) gap = $urandom_range(0, gap_limit);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= wr;
      req_bus_address <= addr;
      req_write_data  <= wdata;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The transfer happened at this edge; queue what it should produce.
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         pending_results.push_back(predict_access(cur_lorom, cur_mask, wr, addr, wdata));
      end
   endtask

   // Drain the decoder, then write both registers back to back.
   task automatic apply_settings(input logic lorom, input logic [MASK_WIDTH-1:0] mask);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAP_LOROM;
      csr_wdata <= MASK_WIDTH'(lorom);
      @(posedge clock);
      csr_index <= CSR_SRAM_MASK;
      csr_wdata <= mask;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_lorom = lorom;
      cur_mask  = mask;
   endtask

   // Result-side stalls: rotate a 16-bit pattern, reload it whenever the 6-bit
   // age counter wraps; the mode picks how dense the stalls are, zero means none.
   always @(posedge clock) begin
      if (stall_age == '0) begin
         case (stall_mode)
            0:       stall_pattern <= '0;
            1:       stall_pattern <= 16'($urandom & $urandom);
            2:       stall_pattern <= 16'($urandom);
            default: stall_pattern <= 16'($urandom | $urandom);
         endcase
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      stall_age <= stall_age + 6'd1;
      rsp_ready <= !stall_pattern[0];
   end

   // Check every result transfer against the oldest queued expectation.
   always @(posedge clock) begin : result_check
      access_result_type got;
      access_result_type want;

      if (!reset && rsp_valid && rsp_ready) begin
         got = '{target_type'(rsp_target), rsp_target_offset, rsp_constant_value,
                 rsp_access_cycles, rsp_is_write, rsp_store_data};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: target %0d offset %06h", got.tgt, got.offset);
         end else begin
            want = pending_results.pop_front();
            if (got.tgt !== want.tgt || got.offset !== want.offset ||
                got.const_val !== want.const_val || got.cycles !== want.cycles ||
                got.is_write !== want.is_write || got.store_data !== want.store_data) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected tgt %0d ofs %06h cval %02h cyc %0d wr %0b data %02h",
                           want.tgt, want.offset, want.const_val, want.cycles,
                           want.is_write, want.store_data);
                  $display("          actual   tgt %0d ofs %06h cval %02h cyc %0d wr %0b data %02h",
                           got.tgt, got.offset, got.const_val, got.cycles,
                           got.is_write, got.store_data);
               end
            end
         end
      end
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** console_bus_address_decoder: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int                    n;
      int                    p;
      int                    k;
      directed_row_type      row;
      logic                  lorom;
      logic [MASK_WIDTH-1:0] mask;
      logic [7:0]            bank;
      logic [15:0]           lo;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; rewrite the registers whenever a row needs
      // a different setting.
      for (n = 0; n < $size(DIRECTED); n++) begin
         row = DIRECTED[n];
         if (row.lorom !== cur_lorom || row.mask !== cur_mask)
            apply_settings(row.lorom, row.mask);
         send_access(row.wr, row.addr, row.wdata, row.typed, row.want);
      end

      // Random accesses: alternate the mapping each phase, vary SRAM sizes
      // between none, full and others, and vary how hard both sides idle.
      for (p = 0; p < PHASE_COUNT; p++) begin
         lorom = (p % 2 == 0);
         case (p)
            0, 3:    mask = '0;
            1, 2:    mask = 13'h1FFF;
            6:       mask = 13'h07FF;
            default: mask = MASK_WIDTH'($urandom_range(0, 8191));
         endcase
         apply_settings(lorom, mask);
         stall_mode = p % 4;
         gap_limit  = (p == 0 || p == 5) ? 0 : 6;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // Aim most banks at the regions the decode splits on.
            case ($urandom_range(0, 9))
               0, 1:    bank = 8'($urandom_range(0, 255));
               2:       bank = 8'($urandom_range(8'h00, 8'h3F));
               3:       bank = 8'($urandom_range(8'h80, 8'hBF));
               4:       bank = 8'($urandom_range(8'h7E, 8'h7F));
               5:       bank = 8'($urandom_range(8'h70, 8'h71));
               6:       bank = 8'($urandom_range(8'h40, 8'h6F));
               7:       bank = 8'($urandom_range(8'hD0, 8'hFF));
               8:       bank = 8'($urandom_range(8'hC0, 8'hCF));
               default: bank = $urandom_range(0, 1) ? 8'h60 : 8'h00;
            endcase
            // Likewise bias the low address toward the register windows.
            case ($urandom_range(0, 5))
               0, 1:    lo = 16'($urandom);
               2:       lo = 16'($urandom_range(16'h4000, 16'h4FFF));
               3:       lo = 16'($urandom_range(16'h4200, 16'h43FF));
               4:       lo = $urandom_range(0, 1) ? 16'h4017 : 16'h4016;
               default: lo = 16'($urandom_range(16'h2000, 16'h7FFF));
            endcase
            send_access(1'($urandom), {bank, lo}, 8'($urandom), 1'b0, NOT_TYPED);
         end
      end

      // Drop valid, let every result drain, then allow the pipeline to
      // settle so any stray transfer is caught.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** console_bus_address_decoder: PASSED **");
      end else begin
         $display("** console_bus_address_decoder: FAILED **");
      end
      $finish;
   end

endmodule
